// ===== hw/rtl/isdt_pkg.sv =====
// Shared types and constants for the ingress slot doorbell table.
package isdt_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam int LINK_W = 16;
  localparam int GEN_W  = 64;
  localparam int TAG_W  = 32;
  localparam int MASK_W = 16;
  localparam int IN_DATA_W  = 184;
  localparam int OUT_DATA_W = 248;

  typedef enum logic [1:0] {
    REQ_ATTACH  = 2'd0,
    REQ_DETACH  = 2'd1,
    REQ_PUBLISH = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_BAD_SLOT  = 3'd1,
    STS_BUSY      = 3'd2,
    STS_EXHAUSTED = 3'd3,
    STS_MISMATCH  = 3'd4
  } status_t;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic              bound;
    logic [LINK_W-1:0] link;
    logic [GEN_W-1:0]  bind_gen;
    logic [GEN_W-1:0]  deliv_gen;
    logic [TAG_W-1:0]  bound_tag;
    logic [TAG_W-1:0]  pub_tag;
  } slot_entry_t;

endpackage

// ===== hw/rtl/isdt_ctrl.sv =====
// Request sequencer and output handshake control for the slot doorbell table.
module isdt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output isdt_pkg::ctrl_cmd_t cmd
);
  import isdt_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CS_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: begin
        if (s_tvalid) state_next = CS_EXEC;
      end
      CS_EXEC: begin
        if (!out_full || m_tready) state_next = CS_IDLE;
      end
      default: state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    s_tready    = 1'b0;
    case (state)
      CS_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      CS_EXEC: begin
        cmd.commit = !out_full || m_tready;
      end
      default: ;
    endcase
    if (cmd.commit) out_full_next = 1'b1;
    else if (m_tready) out_full_next = 1'b0;
    else out_full_next = out_full;
  end

  assign m_tvalid = out_full;

  a_capture_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == CS_EXEC)
    else $error("captured request did not enter execute");

  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("committed result not presented");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == CS_EXEC && out_full && !m_tready) |=> state == CS_EXEC)
    else $error("request left execute while result was stalled");

  a_no_accept_exec: assert property (@(posedge clk) disable iff (rst)
    state == CS_EXEC |-> !s_tready && !cmd.capture)
    else $error("transfer accepted during execute");

endmodule

// ===== hw/rtl/isdt_dp.sv =====
// Slot table, pending mask, sequence counter and result register.
module isdt_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  isdt_pkg::ctrl_cmd_t                cmd,
  input  logic                               cfg_we,
  input  logic                               cfg_wdata,
  input  logic [1:0]                         req_in,
  input  logic [7:0]                         slot_in,
  input  logic [isdt_pkg::LINK_W-1:0]        link_in,
  input  logic [isdt_pkg::GEN_W-1:0]         bgen_in,
  input  logic [isdt_pkg::GEN_W-1:0]         dgen_in,
  input  logic [isdt_pkg::TAG_W-1:0]         tag_in,
  output logic [2:0]                         status_out,
  output logic [isdt_pkg::GEN_W-1:0]         bgen_out,
  output logic                               act_out,
  output logic [isdt_pkg::MASK_W-1:0]        mask_out,
  output logic [isdt_pkg::GEN_W-1:0]         seq_out,
  output logic [isdt_pkg::GEN_W-1:0]         sgen_out,
  output logic [isdt_pkg::TAG_W-1:0]         stag_out
);
  import isdt_pkg::*;

  localparam logic [8:0] SLOT_LIMIT = 9'(SLOT_COUNT);

  logic                  admission_closed;
  slot_entry_t           table_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] entry_valid;
  logic [SLOT_COUNT-1:0] pending_mask;
  logic [GEN_W-1:0]      pending_seq;

  req_t              req_q;
  logic [7:0]        slot_q;
  logic [LINK_W-1:0] link_q;
  logic [GEN_W-1:0]  bgen_q;
  logic [GEN_W-1:0]  dgen_q;
  logic [TAG_W-1:0]  tag_q;

  logic                   bad;
  logic [SLOT_IW-1:0]     idx;
  slot_entry_t            cur, nxt;
  logic                   owner;
  status_t                status;
  logic [GEN_W-1:0]       gen_inc;
  logic [GEN_W-1:0]       gen_res;
  logic                   act;
  logic [SLOT_COUNT-1:0]  mask_next;
  logic [GEN_W-1:0]       seq_next;
  logic [SLOT_COUNT+MASK_W-1:0] mask_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      admission_closed <= 1'b0;
    end else if (cfg_we) begin
      admission_closed <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q  <= req_t'(req_in);
      slot_q <= slot_in;
      link_q <= link_in;
      bgen_q <= bgen_in;
      dgen_q <= dgen_in;
      tag_q  <= tag_in;
    end
  end

  assign bad     = {1'b0, slot_q} >= SLOT_LIMIT;
  assign idx     = slot_q[SLOT_IW-1:0];
  assign cur     = entry_valid[idx] ? table_q[idx] : '0;
  assign owner   = cur.bound && (cur.link == link_q) && (cur.bind_gen == bgen_q);
  assign gen_inc = cur.bind_gen + GEN_W'(1);

  always_comb begin
    nxt       = cur;
    status    = STS_OK;
    gen_res   = '0;
    act       = 1'b0;
    mask_next = pending_mask;
    seq_next  = pending_seq;
    if (bad) begin
      status = STS_BAD_SLOT;
    end else begin
      case (req_q)
        REQ_ATTACH: begin
          if (admission_closed || cur.bound) begin
            status = STS_BUSY;
          end else if (&cur.bind_gen) begin
            status = STS_EXHAUSTED;
          end else begin
            nxt.bind_gen  = gen_inc;
            nxt.bound     = 1'b1;
            nxt.link      = link_q;
            nxt.deliv_gen = '0;
            nxt.bound_tag = tag_q;
            gen_res       = gen_inc;
          end
        end
        REQ_DETACH: begin
          if (!owner) begin
            status = STS_MISMATCH;
          end else begin
            nxt.bound     = 1'b0;
            nxt.link      = '0;
            nxt.deliv_gen = '0;
            nxt.bound_tag = '0;
            nxt.pub_tag   = '0;
            mask_next[idx] = 1'b0;
          end
        end
        REQ_PUBLISH: begin
          if (!owner || cur.bound_tag != tag_q) begin
            status = STS_MISMATCH;
          end else begin
            nxt.deliv_gen = dgen_q;
            nxt.pub_tag   = tag_q;
            if (!pending_mask[idx] && !(&pending_seq)) seq_next = pending_seq + GEN_W'(1);
            mask_next[idx] = 1'b1;
            act = 1'b1;
          end
        end
        REQ_CLEAR: begin
          if (!owner || cur.deliv_gen > dgen_q) begin
            status = STS_MISMATCH;
          end else begin
            nxt.deliv_gen  = '0;
            mask_next[idx] = 1'b0;
          end
        end
        default: status = STS_MISMATCH;
      endcase
    end
  end

  assign mask_ext = {{MASK_W{1'b0}}, mask_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= '0;
      pending_mask <= '0;
      pending_seq  <= '0;
    end else if (cmd.commit) begin
      pending_mask <= mask_next;
      pending_seq  <= seq_next;
      if (!bad) entry_valid[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !bad) begin
      table_q[idx] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_out <= status;
      bgen_out   <= gen_res;
      act_out    <= act;
      mask_out   <= mask_ext[MASK_W-1:0];
      seq_out    <= seq_next;
      sgen_out   <= bad ? '0 : nxt.deliv_gen;
      stag_out   <= bad ? '0 : nxt.pub_tag;
    end
  end

  a_seq_mono: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> pending_seq >= $past(pending_seq))
    else $error("pending sequence went backward");

  a_bad_nochange: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && bad) |=> pending_mask == $past(pending_mask) && status_out == STS_BAD_SLOT)
    else $error("bad slot request changed the mask");

  a_act_ok: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && act) |=> status_out == STS_OK && mask_out == $past(mask_ext[MASK_W-1:0]))
    else $error("activate raised on a failed request");

endmodule

// ===== hw/rtl/ingress_slot_doorbell_table_top.sv =====
// Top level of the ingress slot doorbell table: stream ports and config register.
// m_tvalid rises once the execute state has committed the result of the accepted input
// transfer, which is captured on acceptance; the result register is loaded on commit.
// A new request is accepted only in the idle state, after the previous one has executed;
// execute waits while the previous result is still not taken.
// Reset (rst, synchronous): clears the sequencer, output valid, slot entries, pending
// mask, pending sequence and admission_closed.
module ingress_slot_doorbell_table_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // slot[7:0], link_id[23:8], binding_gen_in[87:24], delivery_gen_in[151:88],
  // tag_in[183:152]
  input  logic [183:0] s_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[2:0], binding_gen_out[66:3], activate[67], mask_out[83:68],
  // sequence_out[147:84], slot_gen_out[211:148], slot_tag_out[243:212], zero[247:244]
  output logic [247:0] m_tdata
);
  import isdt_pkg::*;

  ctrl_cmd_t         cmd;
  logic [2:0]        status;
  logic [GEN_W-1:0]  bgen_out;
  logic              act;
  logic [MASK_W-1:0] mask_out;
  logic [GEN_W-1:0]  seq_out;
  logic [GEN_W-1:0]  sgen_out;
  logic [TAG_W-1:0]  stag_out;

  isdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  isdt_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req_in     (s_tuser),
    .slot_in    (s_tdata[7:0]),
    .link_in    (s_tdata[23:8]),
    .bgen_in    (s_tdata[87:24]),
    .dgen_in    (s_tdata[151:88]),
    .tag_in     (s_tdata[183:152]),
    .status_out (status),
    .bgen_out   (bgen_out),
    .act_out    (act),
    .mask_out   (mask_out),
    .seq_out    (seq_out),
    .sgen_out   (sgen_out),
    .stag_out   (stag_out)
  );

  assign m_tdata = {4'b0, stag_out, sgen_out, seq_out, mask_out, act, bgen_out, status};

endmodule
